### rtl/tmcl_pkg.sv
package tmcl_pkg;

    // Field and register widths.
    localparam int FORMAT_W   = 64;
    localparam int DIM_W      = 16;
    localparam int LEVEL_W    = 5;
    localparam int META_W     = 32;
    localparam int FLEN_W     = 36;
    localparam int OFFSET_W   = 34;
    localparam int BYTES_W    = 33;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;

    // Reciprocal multiply for the block-count division.
    localparam int RCP_SHIFT  = 22;
    localparam int RCP_W      = 21;
    localparam int MUL_A_W    = 17;
    localparam int PROD_W     = MUL_A_W + RCP_W;
    localparam int QUOT_W     = PROD_W - RCP_SHIFT;

    localparam int MAX_LEVELS   = 17;
    localparam int HEADER_BYTES = 52;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEPTH  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FORMAT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DEPTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_METADATA_BYTES = 3'd5;

    // Per-format block geometry. The block count along an axis is
    // ((dim + pad) * rcp) >> RCP_SHIFT, and the level size is the block
    // count shifted left by size_shift.
    typedef struct packed {
        logic             ok;
        logic [3:0]       pad_x;
        logic [3:0]       pad_y;
        logic [RCP_W-1:0] rcp_x;
        logic [RCP_W-1:0] rcp_y;
        logic [2:0]       size_shift;
    } fmt_t;

    // ceil(2^RCP_SHIFT / d) for every block edge in use.
    function automatic logic [RCP_W-1:0] block_rcp(input logic [4:0] d);
        logic [RCP_W-1:0] r;
        begin
            unique case (d)
                5'd4:    r = 21'd1048576;
                5'd5:    r = 21'd838861;
                5'd6:    r = 21'd699051;
                5'd8:    r = 21'd524288;
                5'd10:   r = 21'd419431;
                5'd12:   r = 21'd349526;
                5'd16:   r = 21'd262144;
                default: r = 21'd1048576;
            endcase
            return r;
        end
    endfunction

    function automatic fmt_t fmt_lookup(input logic [FORMAT_W-1:0] code);
        fmt_t       f;
        logic [4:0] bw;
        logic [4:0] bh;
        begin
            f  = '0;
            bw = 5'd4;
            bh = 5'd4;
            f.ok = (code[FORMAT_W-1:6] == '0);
            case (code[5:0]) inside
                6'd0, 6'd1:
                begin
                    bw = 5'd16; bh = 5'd8; f.size_shift = 3'd5;
                end
                6'd2, 6'd3:
                begin
                    bw = 5'd8; bh = 5'd8; f.size_shift = 3'd5;
                end
                6'd6, 6'd7, 6'd12, 6'd22, 6'd24, 6'd25:
                begin
                    f.size_shift = 3'd3;
                end
                6'd9, 6'd11, 6'd13, 6'd14, 6'd15, 6'd23, 6'd26:
                begin
                    f.size_shift = 3'd4;
                end
                6'd27: begin bw = 5'd4;  bh = 5'd4;  f.size_shift = 3'd4; end
                6'd28: begin bw = 5'd5;  bh = 5'd4;  f.size_shift = 3'd4; end
                6'd29: begin bw = 5'd5;  bh = 5'd5;  f.size_shift = 3'd4; end
                6'd30: begin bw = 5'd6;  bh = 5'd5;  f.size_shift = 3'd4; end
                6'd31: begin bw = 5'd6;  bh = 5'd6;  f.size_shift = 3'd4; end
                6'd32: begin bw = 5'd8;  bh = 5'd5;  f.size_shift = 3'd4; end
                6'd33: begin bw = 5'd8;  bh = 5'd6;  f.size_shift = 3'd4; end
                6'd34: begin bw = 5'd8;  bh = 5'd8;  f.size_shift = 3'd4; end
                6'd35: begin bw = 5'd10; bh = 5'd5;  f.size_shift = 3'd4; end
                6'd36: begin bw = 5'd10; bh = 5'd6;  f.size_shift = 3'd4; end
                6'd37: begin bw = 5'd10; bh = 5'd8;  f.size_shift = 3'd4; end
                6'd38: begin bw = 5'd10; bh = 5'd10; f.size_shift = 3'd4; end
                6'd39: begin bw = 5'd12; bh = 5'd10; f.size_shift = 3'd4; end
                6'd40: begin bw = 5'd12; bh = 5'd12; f.size_shift = 3'd4; end
                default:
                begin
                    f.ok = 1'b0;
                end
            endcase
            f.pad_x = 4'(bw - 5'd1);
            f.pad_y = 4'(bh - 5'd1);
            f.rcp_x = block_rcp(bw);
            f.rcp_y = block_rcp(bh);
            return f;
        end
    endfunction

endpackage

### rtl/texture_mip_chain_layout.sv
// Mip chain layout for a block-compressed texture with a 52-byte header.
// A request is checked for depth and format first; a failure gives a single rejection beat.
// A valid chain is summed level by level through the multiplier steps, the file length
// is checked against the total (a short file gives a rejection beat), and the levels are
// computed again and emitted as one beat each. Throughput: one request at a time.
// Reset (rst_n low, asynchronous) idles the sequencer and loads register defaults.
module texture_mip_chain_layout
    import tmcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [FORMAT_W-1:0]   cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [FLEN_W-1:0]     file_length,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [LEVEL_W-1:0]    level_index,
    output logic [DIM_W-1:0]      level_width,
    output logic [DIM_W-1:0]      level_height,
    output logic [OFFSET_W-1:0]   level_offset,
    output logic [BYTES_W-1:0]    level_bytes,
    output logic                  last
);

    // Sequencer states. Each level runs through three multiplier steps:
    // block count across, block count down, then block area.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_MULX   = 3'd2;
    localparam logic [2:0] S_MULY   = 3'd3;
    localparam logic [2:0] S_MULA   = 3'd4;
    localparam logic [2:0] S_LENCHK = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    // Configuration registers.
    logic [FORMAT_W-1:0] pixel_format_reg;
    logic [DIM_W-1:0]    base_width_reg;
    logic [DIM_W-1:0]    base_height_reg;
    logic [DIM_W-1:0]    base_depth_reg;
    logic [LEVEL_W-1:0]  level_count_reg;
    logic [META_W-1:0]   metadata_bytes_reg;

    // Sequencer state.
    logic [2:0]          state_reg, state_next;
    logic                pass_reg, pass_next;     // 0 sums sizes, 1 emits levels
    logic [LEVEL_W-1:0]  lvl_reg, lvl_next;
    logic [OFFSET_W-1:0] total_reg, total_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;

    // Working values.
    logic [FLEN_W-1:0]   flen_reg, flen_next;
    logic [QUOT_W-1:0]   qx_reg, qx_next;
    logic [QUOT_W-1:0]   qy_reg, qy_next;

    // Output beat registers.
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [LEVEL_W-1:0]  index_reg, index_next;
    logic [DIM_W-1:0]    width_reg, width_next;
    logic [DIM_W-1:0]    height_reg, height_next;
    logic [OFFSET_W-1:0] loff_reg, loff_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic                last_reg, last_next;

    fmt_t                fmt;
    logic [LEVEL_W-1:0]  n_lvl;
    logic                final_lvl;
    logic [DIM_W-1:0]    w_shift;
    logic [DIM_W-1:0]    h_shift;
    logic [DIM_W-1:0]    w_lvl;
    logic [DIM_W-1:0]    h_lvl;
    logic [MUL_A_W-1:0]  mul_a;
    logic [RCP_W-1:0]    mul_b;
    logic [PROD_W-1:0]   product;
    logic [PROD_W+7-1:0] size_wide;
    logic [BYTES_W-1:0]  lvl_size;
    logic [FLEN_W-1:0]   need_bytes;

    // Block geometry of the configured format; the user must keep the register stable while busy (not enforced here).
    assign fmt = fmt_lookup(pixel_format_reg);

    // Level count saturates at the largest chain the block lays out.
    assign n_lvl = ({1'b0, level_count_reg} > 6'(MAX_LEVELS)) ?
                   LEVEL_W'(MAX_LEVELS) : level_count_reg;
    assign final_lvl = (lvl_reg == n_lvl - 5'd1);

    // Level dimensions halve per level with a floor of one pixel.
    assign w_shift = base_width_reg >> lvl_reg;
    assign h_shift = base_height_reg >> lvl_reg;
    assign w_lvl   = (w_shift == '0) ? DIM_W'(1) : w_shift;
    assign h_lvl   = (h_shift == '0) ? DIM_W'(1) : h_shift;

    // The shared multiplier. In the first two steps it divides the padded
    // dimension by the block edge through a reciprocal; in the third it
    // forms the block area from the two registered counts.
    always_comb
    begin
        unique case (state_reg)
            S_MULX:
            begin
                mul_a = MUL_A_W'(w_lvl) + MUL_A_W'(fmt.pad_x);
                mul_b = fmt.rcp_x;
            end
            S_MULY:
            begin
                mul_a = MUL_A_W'(h_lvl) + MUL_A_W'(fmt.pad_y);
                mul_b = fmt.rcp_y;
            end
            default:
            begin
                mul_a = MUL_A_W'(qy_reg);
                mul_b = RCP_W'(qx_reg);
            end
        endcase
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Bytes per block are a power of two for every supported format, so the
    // level size is the block area shifted left.
    assign size_wide = (PROD_W+7)'(product) << fmt.size_shift;
    assign lvl_size  = size_wide[BYTES_W-1:0];

    // The file must hold the header, the metadata and the whole chain.
    assign need_bytes = FLEN_W'(HEADER_BYTES) + FLEN_W'(metadata_bytes_reg)
                      + FLEN_W'(total_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);

    assign status       = status_reg;
    assign level_index  = index_reg;
    assign level_width  = width_reg;
    assign level_height = height_reg;
    assign level_offset = loff_reg;
    assign level_bytes  = bytes_reg;
    assign last         = last_reg;

    always_comb
    begin
        state_next  = state_reg;
        pass_next   = pass_reg;
        lvl_next    = lvl_reg;
        total_next  = total_reg;
        offset_next = offset_reg;
        flen_next   = flen_reg;
        qx_next     = qx_reg;
        qy_next     = qy_reg;
        status_next = status_reg;
        index_next  = index_reg;
        width_next  = width_reg;
        height_next = height_reg;
        loff_next   = loff_reg;
        bytes_next  = bytes_reg;
        last_next   = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    flen_next  = file_length;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                lvl_next    = '0;
                total_next  = '0;
                offset_next = '0;
                pass_next   = 1'b0;
                // A rejection beat carries only the status and the last flag.
                index_next  = '0;
                width_next  = '0;
                height_next = '0;
                loff_next   = '0;
                bytes_next  = '0;
                last_next   = 1'b1;
                if (base_depth_reg > DIM_W'(1))
                begin
                    status_next = ST_DEPTH;
                    state_next  = S_EMIT;
                end
                else if (!fmt.ok)
                begin
                    status_next = ST_FORMAT;
                    state_next  = S_EMIT;
                end
                else if (n_lvl == '0)
                begin
                    state_next = S_LENCHK;
                end
                else
                begin
                    state_next = S_MULX;
                end
            end

            S_MULX:
            begin
                qx_next    = product[PROD_W-1:RCP_SHIFT];
                state_next = S_MULY;
            end

            S_MULY:
            begin
                qy_next    = product[PROD_W-1:RCP_SHIFT];
                state_next = S_MULA;
            end

            S_MULA:
            begin
                if (!pass_reg)
                begin
                    total_next = total_reg + OFFSET_W'(lvl_size);
                    if (final_lvl)
                    begin
                        state_next = S_LENCHK;
                    end
                    else
                    begin
                        lvl_next   = lvl_reg + 5'd1;
                        state_next = S_MULX;
                    end
                end
                else
                begin
                    status_next = ST_OK;
                    index_next  = lvl_reg;
                    width_next  = w_lvl;
                    height_next = h_lvl;
                    loff_next   = offset_reg;
                    bytes_next  = lvl_size;
                    last_next   = final_lvl;
                    state_next  = S_EMIT;
                end
            end

            S_LENCHK:
            begin
                lvl_next    = '0;
                offset_next = '0;
                if (flen_reg < need_bytes)
                begin
                    status_next = ST_SHORT;
                    last_next   = 1'b1;
                    state_next  = S_EMIT;
                end
                else if (n_lvl == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    pass_next  = 1'b1;
                    state_next = S_MULX;
                end
            end

            S_EMIT:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        offset_next = offset_reg + OFFSET_W'(bytes_reg);
                        lvl_next    = lvl_reg + 5'd1;
                        state_next  = S_MULX;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            pass_reg           <= 1'b0;
            lvl_reg            <= '0;
            total_reg          <= '0;
            offset_reg         <= '0;
            pixel_format_reg   <= '0;
            base_width_reg     <= DIM_W'(1);
            base_height_reg    <= DIM_W'(1);
            base_depth_reg     <= DIM_W'(1);
            level_count_reg    <= LEVEL_W'(1);
            metadata_bytes_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pass_reg   <= pass_next;
            lvl_reg    <= lvl_next;
            total_reg  <= total_next;
            offset_reg <= offset_next;
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    REG_PIXEL_FORMAT:   pixel_format_reg   <= cfg_data;
                    REG_BASE_WIDTH:     base_width_reg     <= cfg_data[DIM_W-1:0];
                    REG_BASE_HEIGHT:    base_height_reg    <= cfg_data[DIM_W-1:0];
                    REG_BASE_DEPTH:     base_depth_reg     <= cfg_data[DIM_W-1:0];
                    REG_LEVEL_COUNT:    level_count_reg    <= cfg_data[LEVEL_W-1:0];
                    REG_METADATA_BYTES: metadata_bytes_reg <= cfg_data[META_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        flen_reg   <= flen_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        width_reg  <= width_next;
        height_reg <= height_next;
        loff_reg   <= loff_next;
        bytes_reg  <= bytes_next;
        last_reg   <= last_next;
    end

endmodule

### test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmcl_pkg::*;

    // Format codes the bench uses. Codes 4, 5, 8, 10, 16-21 and anything above
    // 40 are not laid out by the block and must be rejected.
    localparam logic [FORMAT_W-1:0] FMT_PVRTC1_2BPP_RGB  = 64'd0;
    localparam logic [FORMAT_W-1:0] FMT_PVRTC1_2BPP_RGBA = 64'd1;
    localparam logic [FORMAT_W-1:0] FMT_PVRTC1_4BPP_RGB  = 64'd2;
    localparam logic [FORMAT_W-1:0] FMT_PVRTC1_4BPP_RGBA = 64'd3;
    localparam logic [FORMAT_W-1:0] FMT_PVRTC2_2BPP      = 64'd4;
    localparam logic [FORMAT_W-1:0] FMT_ETC1             = 64'd6;
    localparam logic [FORMAT_W-1:0] FMT_DXT1             = 64'd7;
    localparam logic [FORMAT_W-1:0] FMT_DXT2             = 64'd8;
    localparam logic [FORMAT_W-1:0] FMT_DXT3             = 64'd9;
    localparam logic [FORMAT_W-1:0] FMT_DXT5             = 64'd11;
    localparam logic [FORMAT_W-1:0] FMT_BC4              = 64'd12;
    localparam logic [FORMAT_W-1:0] FMT_BC5              = 64'd13;
    localparam logic [FORMAT_W-1:0] FMT_BC6              = 64'd14;
    localparam logic [FORMAT_W-1:0] FMT_BC7              = 64'd15;
    localparam logic [FORMAT_W-1:0] FMT_ETC2_RGB         = 64'd22;
    localparam logic [FORMAT_W-1:0] FMT_ETC2_RGBA        = 64'd23;
    localparam logic [FORMAT_W-1:0] FMT_ETC2_RGB_A1      = 64'd24;
    localparam logic [FORMAT_W-1:0] FMT_EAC_R11          = 64'd25;
    localparam logic [FORMAT_W-1:0] FMT_EAC_RG11         = 64'd26;
    localparam logic [FORMAT_W-1:0] FMT_ASTC_4X4         = 64'd27;
    localparam logic [FORMAT_W-1:0] FMT_ASTC_12X12       = 64'd40;

    // ASTC block footprints, in code order starting at 4x4.
    localparam int ASTC_BLOCK_W [14] = '{4, 5, 5, 6, 6, 8, 8, 8, 10, 10, 10, 10, 12, 12};
    localparam int ASTC_BLOCK_H [14] = '{4, 4, 5, 5, 6, 5, 6, 8, 5, 6, 8, 10, 10, 12};
    localparam int ASTC_BLOCK_BYTES = 16;

    localparam logic [FLEN_W-1:0] FLEN_MAX    = '1;
    localparam longint unsigned   OFFSET_MASK = (64'd1 << OFFSET_W) - 1;

    // The longest chain can still be running when its last beat could already have
    // been predicted, so DRAIN_CYCLES quiet cycles are taken to prove the block is idle.
    localparam int DRAIN_CYCLES = 130;
    localparam int HOLD_CYCLES  = 400;
    localparam int ROUNDS       = 16;
    localparam int ROUND_ITEMS  = 24;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEVEL_W-1:0]  level;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [OFFSET_W-1:0] offset;
        logic [BYTES_W-1:0]  size_bytes;
        logic                last;
    } level_beat_t;

    // Mirrors the register file, predicts the level beats of every accepted
    // request and checks the beats that leave the block in order.
    class mip_layout_checker;
        logic [FORMAT_W-1:0] fmt_code;
        logic [DIM_W-1:0]    top_w;
        logic [DIM_W-1:0]    top_h;
        logic [DIM_W-1:0]    depth;
        logic [LEVEL_W-1:0]  levels;
        logic [META_W-1:0]   meta_len;
        longint unsigned     blk_w;
        longint unsigned     blk_h;
        longint unsigned     blk_bpp;
        bit                  is_astc;
        level_beat_t         expected_levels[$];
        int                  mismatches;

        function new();
            fmt_code   = '0;
            top_w      = 16'd1;
            top_h      = 16'd1;
            depth      = 16'd1;
            levels     = 5'd1;
            meta_len   = '0;
            mismatches = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FORMAT_W-1:0] data);
            case (idx)
                REG_PIXEL_FORMAT:   fmt_code = data;
                REG_BASE_WIDTH:     top_w    = data[DIM_W-1:0];
                REG_BASE_HEIGHT:    top_h    = data[DIM_W-1:0];
                REG_BASE_DEPTH:     depth    = data[DIM_W-1:0];
                REG_LEVEL_COUNT:    levels   = data[LEVEL_W-1:0];
                REG_METADATA_BYTES: meta_len = data[META_W-1:0];
                default: ;
            endcase
        endfunction

        function bit decode_format();
            blk_w   = 4;
            blk_h   = 4;
            blk_bpp = 0;
            is_astc = 1'b0;
            if (fmt_code >= FMT_ASTC_4X4 && fmt_code <= FMT_ASTC_12X12)
            begin
                is_astc = 1'b1;
                blk_w   = ASTC_BLOCK_W[int'(fmt_code - FMT_ASTC_4X4)];
                blk_h   = ASTC_BLOCK_H[int'(fmt_code - FMT_ASTC_4X4)];
                return 1'b1;
            end
            case (fmt_code)
                FMT_PVRTC1_2BPP_RGB, FMT_PVRTC1_2BPP_RGBA:
                begin
                    blk_w = 16; blk_h = 8; blk_bpp = 2;
                    return 1'b1;
                end
                FMT_PVRTC1_4BPP_RGB, FMT_PVRTC1_4BPP_RGBA:
                begin
                    blk_w = 8; blk_h = 8; blk_bpp = 4;
                    return 1'b1;
                end
                FMT_ETC1, FMT_DXT1, FMT_BC4, FMT_ETC2_RGB, FMT_ETC2_RGB_A1, FMT_EAC_R11:
                begin
                    blk_bpp = 4;
                    return 1'b1;
                end
                FMT_DXT3, FMT_DXT5, FMT_BC5, FMT_BC6, FMT_BC7, FMT_ETC2_RGBA, FMT_EAC_RG11:
                begin
                    blk_bpp = 8;
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        function longint unsigned level_dim(input logic [DIM_W-1:0] top, input int lvl);
            logic [DIM_W-1:0] d;
            d = top >> lvl;
            return (d == 0) ? 1 : d;
        endfunction

        function longint unsigned level_size(input int lvl);
            longint unsigned w;
            longint unsigned h;
            longint unsigned bx;
            longint unsigned by;
            w  = level_dim(top_w, lvl);
            h  = level_dim(top_h, lvl);
            bx = (w + blk_w - 1) / blk_w;
            by = (h + blk_h - 1) / blk_h;
            if (is_astc)
                return bx * by * ASTC_BLOCK_BYTES;
            return (blk_bpp * (bx * blk_w) * (by * blk_h)) / 8;
        endfunction

        function int level_limit();
            return (levels > MAX_LEVELS) ? MAX_LEVELS : int'(levels);
        endfunction

        // Bytes needed for header, metadata and the whole chain. For a format
        // that is rejected anyway only header and metadata count.
        function longint unsigned required_length();
            longint unsigned need;
            int              lvl;
            longint unsigned chain;
            need = meta_len;
            need += HEADER_BYTES;
            if (!decode_format())
                return need;
            chain = 0;
            for (lvl = 0; lvl < level_limit(); lvl++)
                chain += level_size(lvl);
            return need + (chain & OFFSET_MASK);
        endfunction

        function void push_status(input logic [STATUS_W-1:0] st);
            level_beat_t beat;
            beat        = '0;
            beat.status = st;
            beat.last   = 1'b1;
            expected_levels = {expected_levels, beat};
        endfunction

        function void note_request(input logic [FLEN_W-1:0] flen);
            level_beat_t     beat;
            longint unsigned offset;
            longint unsigned size_now;
            int              lvl;
            if (depth > 1)
                push_status(ST_DEPTH);
            else if (!decode_format())
                push_status(ST_FORMAT);
            else if (flen < required_length())
                push_status(ST_SHORT);
            else
            begin
                // A level count of zero passes every check and yields nothing.
                offset = 0;
                for (lvl = 0; lvl < level_limit(); lvl++)
                begin
                    size_now        = level_size(lvl);
                    beat.status     = ST_OK;
                    beat.level      = LEVEL_W'(lvl);
                    beat.width      = DIM_W'(level_dim(top_w, lvl));
                    beat.height     = DIM_W'(level_dim(top_h, lvl));
                    beat.offset     = OFFSET_W'(offset);
                    beat.size_bytes = BYTES_W'(size_now);
                    beat.last       = (lvl + 1 == level_limit());
                    expected_levels = {expected_levels, beat};
                    offset = (offset + size_now) & OFFSET_MASK;
                end
            end
        endfunction

        function void flag(input string field, input logic [LEVEL_W-1:0] lvl,
                           input logic [63:0] want_v, input logic [63:0] got_v);
            mismatches++;
            $display("%0t: level %0d %s expected 'h%0h got 'h%0h",
                     $time, lvl, field, want_v, got_v);
        endfunction

        function void check_level(input level_beat_t got);
            level_beat_t want;
            if (expected_levels.size() == 0)
            begin
                flag("beat (none expected)", got.level, '0, 64'(got.status));
                return;
            end
            want = expected_levels.pop_front();
            if (got.status !== want.status)
                flag("status", want.level, 64'(want.status), 64'(got.status));
            if (got.level !== want.level)
                flag("level_index", want.level, 64'(want.level), 64'(got.level));
            if (got.width !== want.width)
                flag("level_width", want.level, 64'(want.width), 64'(got.width));
            if (got.height !== want.height)
                flag("level_height", want.level, 64'(want.height), 64'(got.height));
            if (got.offset !== want.offset)
                flag("level_offset", want.level, 64'(want.offset), 64'(got.offset));
            if (got.size_bytes !== want.size_bytes)
                flag("level_bytes", want.level, 64'(want.size_bytes),
                     64'(got.size_bytes));
            if (got.last !== want.last)
                flag("last", want.level, 64'(want.last), 64'(got.last));
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wen     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [FORMAT_W-1:0]  cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [FLEN_W-1:0]    file_length = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [LEVEL_W-1:0]   level_index;
    logic [DIM_W-1:0]     level_width;
    logic [DIM_W-1:0]     level_height;
    logic [OFFSET_W-1:0]  level_offset;
    logic [BYTES_W-1:0]   level_bytes;
    logic                 last;

    // Idle percentages of both sides, and the receiver's remaining hold-off.
    int send_idle_pct  = 14;
    int recv_idle_pct  = 63;
    int recv_hold_left = 0;

    mip_layout_checker board = new();

    texture_mip_chain_layout u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .file_length  (file_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .level_index  (level_index),
        .level_width  (level_width),
        .level_height (level_height),
        .level_offset (level_offset),
        .level_bytes  (level_bytes),
        .last         (last)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side. Ready changes only on the falling edge. A requested
    // hold-off keeps ready low for a counted stretch, otherwise ready drops
    // at random according to the current idle percentage.
    always @(negedge clk)
    begin
        if (recv_hold_left > 0)
        begin
            out_ready = 1'b0;
            recv_hold_left--;
        end
        else
            out_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Every beat taken on a rising edge is checked against the oldest
    // prediction. Values are read before the edge's updates land.
    always @(posedge clk)
    begin
        level_beat_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.status     = status;
            got.level      = level_index;
            got.width      = level_width;
            got.height     = level_height;
            got.offset     = level_offset;
            got.size_bytes = level_bytes;
            got.last       = last;
            board.check_level(got);
        end
    end

    // Offers one request and returns on the falling edge after it is taken.
    // Valid is only lowered for an idle gap, never between two beats that
    // follow each other directly.
    task automatic send_request(input logic [FLEN_W-1:0] flen);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        file_length = flen;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(flen);
        @(negedge clk);
    endtask

    // Stops offering and waits until every predicted beat has come back.
    task automatic drain_results();
        in_valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    // A request with a zero level count leaves no beat behind, so the block
    // may still be busy when the queue is empty; give it its full latency.
    task automatic wait_idle();
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FORMAT_W-1:0] data);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        board.set_reg(idx, data);
        @(negedge clk);
    endtask

    // Loads all six registers once the block is idle.
    task automatic configure(input logic [FORMAT_W-1:0] fmt, w, h, d, lv, meta);
        wait_idle();
        write_reg(REG_PIXEL_FORMAT, fmt);
        write_reg(REG_BASE_WIDTH, w);
        write_reg(REG_BASE_HEIGHT, h);
        write_reg(REG_BASE_DEPTH, d);
        write_reg(REG_LEVEL_COUNT, lv);
        write_reg(REG_METADATA_BYTES, meta);
        cfg_wen = 1'b0;
    endtask

    // The register pickers leave random junk above each register's width so
    // that every data bit toggles; only the low bits may matter.
    function automatic logic [FORMAT_W-1:0] pick_format();
        logic [FORMAT_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            8:       ;
            9:       v[5:0] = 6'($urandom_range(40));
            default: v = FORMAT_W'($urandom_range(48));
        endcase
        return v;
    endfunction

    function automatic logic [FORMAT_W-1:0] pick_dim();
        logic [FORMAT_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0:          v[DIM_W-1:0] = DIM_W'($urandom_range(3));
            1, 2, 3, 4: v[DIM_W-1:0] = DIM_W'($urandom_range(64, 1));
            5, 6:       ;
            7:          v[DIM_W-1:0] = '1;
            default:    v[DIM_W-1:0] = DIM_W'(1) << $urandom_range(15);
        endcase
        return v;
    endfunction

    function automatic logic [FORMAT_W-1:0] pick_depth();
        logic [FORMAT_W-1:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(3) != 0)
            v[DIM_W-1:0] = DIM_W'($urandom_range(1));
        return v;
    endfunction

    function automatic logic [FORMAT_W-1:0] pick_levels();
        logic [FORMAT_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       v[LEVEL_W-1:0] = '0;
            1:       v[LEVEL_W-1:0] = LEVEL_W'($urandom_range(31, MAX_LEVELS + 1));
            default: v[LEVEL_W-1:0] = LEVEL_W'($urandom_range(MAX_LEVELS, 1));
        endcase
        return v;
    endfunction

    function automatic logic [FORMAT_W-1:0] pick_meta();
        logic [FORMAT_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v[META_W-1:0] = META_W'($urandom_range(255));
            5, 6, 7:       ;
            8:             v[META_W-1:0] = '1;
            default:       v[META_W-1:0] = '0;
        endcase
        return v;
    endfunction

    // File lengths cluster around the exact requirement so that both sides
    // of the length check are hit often, with fully random lengths mixed in.
    function automatic logic [FLEN_W-1:0] pick_length();
        longint unsigned need;
        need = board.required_length();
        case ($urandom_range(9))
            0, 1, 2, 3: return FLEN_W'(need + $urandom_range(4095));
            4:          return FLEN_W'(need);
            5:          return FLEN_W'(need - 1);
            6, 7:       return FLEN_W'({$urandom, $urandom});
            8:          return FLEN_MAX;
            default:    return FLEN_W'(need - $urandom_range(4096, 1));
        endcase
    endfunction

    // Safety net: ends the run if the block hangs.
    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int round;
        int item;

        // Reset is held low from the start and released on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The reset registers describe one 1x1 level of
        // 2 bpp PVRTC, which pads to a full 16x8 block.
        send_request('0);
        send_request(FLEN_W'(board.required_length() - 1));
        send_request(FLEN_W'(board.required_length()));
        send_request(FLEN_MAX);

        // Largest chain: 17 levels of 65535x65535 ASTC 12x12 behind the largest
        // metadata block, with zero depth taken as one slice.
        configure(FMT_ASTC_12X12, 64'hFFFF, 64'hFFFF, 64'd0, 64'(MAX_LEVELS), 64'hFFFF_FFFF);
        send_request(FLEN_W'(board.required_length()));
        send_request(FLEN_W'(board.required_length() - 1));
        send_request(FLEN_MAX);

        // Unsupported formats: all ones, a valid code with high bits set, a
        // gap code inside the known range and the first code past ASTC.
        configure('1, 64'd64, 64'd64, 64'd1, 64'd4, 64'd0);
        send_request(FLEN_MAX);
        configure(64'h40 | FMT_DXT1, 64'd64, 64'd64, 64'd1, 64'd4, 64'd0);
        send_request(FLEN_MAX);
        configure(FMT_DXT2, 64'd64, 64'd64, 64'd1, 64'd4, 64'd0);
        send_request(FLEN_MAX);
        configure(FMT_ASTC_12X12 + 1, 64'd64, 64'd64, 64'd1, 64'd4, 64'd0);
        send_request(FLEN_MAX);

        // Depth above one is rejected, and that check comes before the
        // format check.
        configure(FMT_DXT1, 64'd64, 64'd64, 64'd2, 64'd4, 64'd0);
        send_request(FLEN_MAX);
        configure(FMT_PVRTC2_2BPP, 64'd64, 64'd64, 64'hFFFF, 64'd4, 64'd0);
        send_request(FLEN_MAX);

        // Zero level count: checks still run, a passing request gives nothing.
        // Zero width and height are treated as one pixel.
        configure(FMT_DXT1, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
        send_request(FLEN_MAX);
        send_request(FLEN_W'(HEADER_BYTES));
        send_request(FLEN_W'(HEADER_BYTES - 1));

        // A level count of 31 saturates to the maximum chain length.
        configure(FMT_DXT5, 64'd1000, 64'd3, 64'd1, 64'd31, 64'd100);
        send_request(FLEN_W'(board.required_length()));
        send_request(FLEN_W'(board.required_length() - 1));

        configure(FMT_PVRTC1_2BPP_RGB, 64'hFFFF, 64'd1, 64'd1, 64'(MAX_LEVELS), 64'd0);
        send_request(FLEN_MAX);

        // Random part in rounds, each with a fresh register setting. The
        // first rounds starve the receiver, the middle ones the sender, and
        // the last rounds run with neither side idling.
        for (round = 0; round < ROUNDS; round++)
        begin
            configure(pick_format(), pick_dim(), pick_dim(), pick_depth(),
                      pick_levels(), pick_meta());
            if (round < 6)
            begin
                send_idle_pct = 14;
                recv_idle_pct = 63;
            end
            else if (round < 11)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 14;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Long receiver stall while requests keep coming, so that the
            // block backs up and has to hold off its input.
            if (round == 12)
                recv_hold_left = HOLD_CYCLES;

            for (item = 0; item < ROUND_ITEMS; item++)
            begin
                // Once, the sender stops mid-round until everything is back.
                if (round == 7 && item == ROUND_ITEMS / 2)
                    drain_results();
                send_request(pick_length());
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
